[hw/rtl/double_ended_queue_top_assert.svh]
// ----------------------------------------------------------------------------
// deque assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define DEQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/deq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and field widths of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  // request and response field widths
  localparam int OP_W        = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 10;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ_BACK  = 3'd4,
    OP_READ_AT    = 3'd5
  } deq_op_t;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } deq_status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic execute;    // run the request against pointers and memory
    logic load_read;  // take registered memory data into the result
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_hit;   // current request reads an occupied entry
  } deq_stat_t;

endpackage

[hw/rtl/double_ended_queue_top.sv]
`timescale 1ns / 1ps
// a request steps through S_ACCESS, then S_READ for a read that hits, then S_RESP
// one request in flight: no new request is accepted until out_tready takes the response
// S_READ is needed because the single port storage has a registered read
// reset: rst_n low clears head and count, storage contents are not cleared
// ----------------------------------------------------------------------------
// double_ended_queue_top
// fixed capacity deque on a ring buffer, one response per request
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // value [31:0], position [41:32], zero [47:42]
  input  logic [deq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // operation [2:0]
  input  logic [deq_pkg::OP_W-1:0]           in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // data [31:0], count [42:32], is_empty [43], zero [47:44]
  output logic [deq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status [1:0]
  output logic [deq_pkg::STATUS_W-1:0]       out_tuser
);

  localparam int PAD_W = deq_pkg::OUT_TDATA_W - deq_pkg::DATA_W - deq_pkg::COUNT_W - 1;

  deq_pkg::deq_cmd_t             cmd;
  deq_pkg::deq_stat_t            stat;
  logic [deq_pkg::DATA_W-1:0]    res_data;
  deq_pkg::deq_status_t          res_status;
  logic [deq_pkg::COUNT_W-1:0]   res_count;
  logic                          res_is_empty;

  // request sequencer
  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // storage and pointers
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_op        (deq_pkg::deq_op_t'(in_tuser)),
    .in_value     (in_tdata[deq_pkg::VALUE_W-1:0]),
    .in_position  (in_tdata[deq_pkg::VALUE_W +: deq_pkg::POS_W]),
    .res_data     (res_data),
    .res_status   (res_status),
    .res_count    (res_count),
    .res_is_empty (res_is_empty)
  );

  // response packing
  assign out_tdata = {{PAD_W{1'b0}}, res_is_empty, res_count, res_data};
  assign out_tuser = res_status;

endmodule

[hw/rtl/deq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// request sequencer: accept, execute, optional memory read, respond
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output deq_pkg::deq_cmd_t  cmd,
  input  deq_pkg::deq_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_READ   = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_ACCESS;
      end
      S_ACCESS: begin
        state_nxt = stat.read_hit ? S_READ : S_RESP;
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshakes and datapath commands
  assign in_tready     = (state_r == S_IDLE);
  assign out_tvalid    = (state_r == S_RESP);
  assign cmd.capture   = (state_r == S_IDLE) && in_tvalid;
  assign cmd.execute   = (state_r == S_ACCESS);
  assign cmd.load_read = (state_r == S_READ);

`include "double_ended_queue_top_assert.svh"

  `DEQ_ASSERT_ALWAYS(a_no_overlap, !(in_tready && out_tvalid), "accept during response")
  `DEQ_ASSERT_NEXT(a_accept_exec, in_tvalid && in_tready, cmd.execute, "request not executed")

endmodule

[hw/rtl/deq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_datapath
// ring buffer storage, head and count pointers, result registers
// ----------------------------------------------------------------------------
module deq_datapath #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  deq_pkg::deq_cmd_t              cmd,
  output deq_pkg::deq_stat_t             stat,
  input  deq_pkg::deq_op_t               in_op,
  input  logic [deq_pkg::VALUE_W-1:0]    in_value,
  input  logic [deq_pkg::POS_W-1:0]      in_position,
  output logic [deq_pkg::DATA_W-1:0]     res_data,
  output deq_pkg::deq_status_t           res_status,
  output logic [deq_pkg::COUNT_W-1:0]    res_count,
  output logic                           res_is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;

  // captured request
  deq_pkg::deq_op_t              op_r;
  logic [deq_pkg::VALUE_W-1:0]   val_r;
  logic [deq_pkg::POS_W-1:0]     pos_r;

  // pointers
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // storage and result
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic [DATA_WIDTH-1:0] res_data_r;
  deq_pkg::deq_status_t  res_status_r;

  logic                 is_full, is_empty, is_push, pos_ok, push_rej;
  logic [XW-1:0]        pos_x;
  logic [AW-1:0]        head_inc, head_dec, offset, slot, mem_addr;
  logic [AW:0]          slot_sum;
  logic                 use_head_dec, we, re;
  deq_pkg::deq_status_t st;

  // capture request on accept
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      val_r <= in_value;
      pos_r <= in_position;
    end
  end

  // occupancy and neighbor pointers
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign is_push  = op_r inside {deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT};
  assign push_rej = cmd.execute && is_push && is_full;
  assign pos_x    = XW'(pos_r);
  assign pos_ok   = (pos_x < XW'(count_r));
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;

  // request decode, ring slot and pointer updates
  always_comb begin
    offset       = '0;
    use_head_dec = 1'b0;
    we           = 1'b0;
    re           = 1'b0;
    st           = deq_pkg::STAT_OK;
    head_nxt     = head_r;
    count_nxt    = count_r;
    case (op_r)
      deq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          st = deq_pkg::STAT_FULL;
        end else begin
          we        = 1'b1;
          offset    = AW'(count_r);
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          st = deq_pkg::STAT_FULL;
        end else begin
          we           = 1'b1;
          use_head_dec = 1'b1;
          head_nxt     = head_dec;
          count_nxt    = count_r + 1'b1;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (is_empty) begin
          st = deq_pkg::STAT_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          st = deq_pkg::STAT_EMPTY;
        end else begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      deq_pkg::OP_READ_BACK: begin
        if (is_empty) begin
          st = deq_pkg::STAT_EMPTY;
        end else begin
          re     = 1'b1;
          offset = AW'(count_r - 1'b1);
        end
      end
      deq_pkg::OP_READ_AT: begin
        if (!pos_ok) begin
          st = deq_pkg::STAT_RANGE;
        end else begin
          re     = 1'b1;
          offset = AW'(pos_x);
        end
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
    // head plus offset wraps at most once
    slot_sum = {1'b0, head_r} + {1'b0, offset};
    if (slot_sum >= (AW + 1)'(DEPTH)) begin
      slot_sum = slot_sum - (AW + 1)'(DEPTH);
    end
    slot     = slot_sum[AW-1:0];
    mem_addr = use_head_dec ? head_dec : slot;
  end

  assign stat.read_hit = re;

  // pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.execute) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // single port storage with registered read
  always_ff @(posedge clk) begin
    if (cmd.execute && we) begin
      mem[mem_addr] <= DATA_WIDTH'(val_r);
    end
    mem_q_r <= mem[mem_addr];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_status_r <= st;
      res_data_r   <= '0;
    end else if (cmd.load_read) begin
      res_data_r   <= mem_q_r;
    end
  end

  assign res_data     = deq_pkg::DATA_W'(res_data_r);
  assign res_status   = res_status_r;
  assign res_count    = deq_pkg::COUNT_W'(count_r);
  assign res_is_empty = is_empty;

`include "double_ended_queue_top_assert.svh"

  `DEQ_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "count above capacity")
  `DEQ_ASSERT_ALWAYS(a_head_bound, head_r <= AW'(DEPTH - 1), "head outside ring")
  `DEQ_ASSERT_NEXT(a_full_hold, push_rej, count_r == $past(count_r), "full push moved count")

endmodule
